@@ hdl/lgm3d_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lgm3d_pkg
// shared types and constants of the 3d log gradient magnitude unit
// ---------------------------------------------------------------------------
package lgm3d_pkg;

    localparam int DEF_MAX_X = 64;
    localparam int DEF_MAX_Y = 64;
    localparam int DEF_MAX_Z = 64;

    localparam int SIZE_W = 7;
    localparam int WORD_W = 32;
    localparam int IDX_W  = 6;
    localparam int REG_W  = 3;

    localparam logic [REG_W-1:0] REG_SIZE_X       = 3'd0;
    localparam logic [REG_W-1:0] REG_SIZE_Y       = 3'd1;
    localparam logic [REG_W-1:0] REG_SIZE_Z       = 3'd2;
    localparam logic [REG_W-1:0] REG_INV_DX       = 3'd3;
    localparam logic [REG_W-1:0] REG_INV_DY       = 3'd4;
    localparam logic [REG_W-1:0] REG_FLOOR_OFFSET = 3'd5;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TABLE  = 1'b1;

    localparam logic [SIZE_W-1:0] SIZE_RESET  = 7'd64;
    localparam logic [WORD_W-1:0] ONE_Q16     = 32'd65536;
    localparam logic [WORD_W-1:0] FLOOR_RESET = 32'd1;
    localparam logic [WORD_W-1:0] LN2_Q30     = 32'd744261118;
    localparam logic [WORD_W-1:0] LOG_ZERO    = 32'h8000_0000;

    typedef struct packed {
        logic [SIZE_W-1:0] size_x;
        logic [SIZE_W-1:0] size_y;
        logic [SIZE_W-1:0] size_z;
        logic [WORD_W-1:0] inv_dx;
        logic [WORD_W-1:0] inv_dy;
        logic [WORD_W-1:0] floor_offset;
    } cfg_t;

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[64] ? {64{1'b1}} : s[63:0];
    endfunction

endpackage

@@ hdl/lgm3d_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lgm3d_ram
// simple dual port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module lgm3d_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

endmodule

@@ hdl/lgm3d_core.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lgm3d_core
// window store, level table and the shared multiply sequencer
// ---------------------------------------------------------------------------
module lgm3d_core
    import lgm3d_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y,
    parameter int MAX_Z = DEF_MAX_Z
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cfg_t                     cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic signed [WORD_W-1:0] sample,
    input  logic [IDX_W-1:0]         level,
    input  logic [WORD_W-1:0]        level_inv_spacing,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] log_grad,
    output logic [IDX_W-1:0]         x_index,
    output logic [IDX_W-1:0]         y_index,
    output logic [IDX_W-1:0]         z_index,
    output logic                     last
);

    localparam int ROW_LEN   = MAX_X + 2;
    localparam int PLANE_LEN = ROW_LEN * (MAX_Y + 2);
    localparam int WS_DEPTH  = 2 * PLANE_LEN;
    localparam int WS_AW     = $clog2(WS_DEPTH);
    localparam int LV_AW     = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int PX_W      = $clog2(MAX_X + 2);
    localparam int PY_W      = $clog2(MAX_Y + 2);
    localparam int PZ_W      = $clog2(MAX_Z + 2);

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_RD5,
        ST_MAG, ST_HMUL, ST_HADD, ST_SQ0, ST_SQ1, ST_SQ2, ST_SQ3, ST_SQACC,
        ST_OFF, ST_NORM, ST_FSQ, ST_FUPD,
        ST_LMUL0, ST_LMUL1, ST_LMUL2, ST_LMUL3, ST_LRND, ST_DONE
    } state_t;

    state_t state_reg;

    logic [PX_W-1:0] pos_x_reg;
    logic [PY_W-1:0] pos_y_reg;
    logic [PZ_W-1:0] pos_z_reg;
    logic [PX_W-1:0] sx;
    logic [PY_W-1:0] sy;
    logic [PZ_W-1:0] sz;

    logic [WS_AW-1:0] cur_addr, oth_addr, c_reg, ws_raddr;
    logic [WORD_W-1:0] ws_rdata, lv_rdata;
    logic [LV_AW-1:0] lv_raddr;
    logic             ws_we, lv_we, accept;
    logic             interior, is_last;
    logic [MAX_Z-1:0] lv_valid_reg;
    logic             lv_vld_reg;

    logic signed [WORD_W-1:0] s_reg, below_reg, xm_reg, xp_reg, ym_reg, yp_reg;
    logic [WORD_W-1:0]        lvl_reg;
    logic [1:0]               comp_reg;
    logic signed [WORD_W-1:0] m_sel, p_sel;
    logic [WORD_W-1:0]        inv_sel;
    logic signed [32:0]       diff;

    logic [32:0]  mag_reg;
    logic [31:0]  inv_reg;
    logic [63:0]  h_reg;
    logic         sat_reg;
    logic [97:0]  acc_reg;
    logic [63:0]  sum_reg, total;
    logic [63:0]  nv_reg, nv_shift;
    logic [6:0]   sh;
    logic [5:0]   e_reg;
    logic [2:0]   step_reg;
    logic [31:0]  x_reg;
    logic [32:0]  t;
    logic [27:0]  frac_reg;
    logic [4:0]   iter_reg;
    logic [6:0]   e_m32;
    logic [34:0]  l2;
    logic [33:0]  lmag_reg;
    logic         lneg_reg;
    logic signed [64:0] pm, q, r;

    logic [31:0]  mul_a, mul_b;
    logic [63:0]  prod_reg, mul_prod_next;

    logic [WORD_W-1:0] res_reg;
    logic [IDX_W-1:0]  xi_reg, yi_reg, zi_reg;
    logic              last_reg;
    logic              out_valid_reg;
    logic              out_load;
    logic signed [WORD_W-1:0] log_grad_reg;
    logic [IDX_W-1:0]  x_index_reg, y_index_reg, z_index_reg;
    logic              last_out_reg;

    // effective sizes
    always_comb
    begin
        if (cfg.size_x == '0)
            sx = PX_W'(1);
        else if (int'(cfg.size_x) > MAX_X)
            sx = PX_W'(MAX_X);
        else
            sx = PX_W'(cfg.size_x);
        if (cfg.size_y == '0)
            sy = PY_W'(1);
        else if (int'(cfg.size_y) > MAX_Y)
            sy = PY_W'(MAX_Y);
        else
            sy = PY_W'(cfg.size_y);
        if (cfg.size_z == '0)
            sz = PZ_W'(1);
        else if (int'(cfg.size_z) > MAX_Z)
            sz = PZ_W'(MAX_Z);
        else
            sz = PZ_W'(cfg.size_z);
    end

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign ws_we    = accept && (operation == OP_SAMPLE);
    assign lv_we    = accept && (operation == OP_TABLE) && (int'(level) < MAX_Z);
    assign lv_raddr = LV_AW'(pos_z_reg - PZ_W'(2));
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);

    assign cur_addr = WS_AW'((pos_z_reg[0] ? PLANE_LEN : 0) + int'(pos_y_reg) * ROW_LEN
                             + int'(pos_x_reg));
    assign oth_addr = WS_AW'((pos_z_reg[0] ? 0 : PLANE_LEN) + int'(pos_y_reg) * ROW_LEN
                             + int'(pos_x_reg));

    assign interior = (pos_z_reg >= PZ_W'(2)) && (pos_z_reg <= sz + PZ_W'(1))
                   && (pos_y_reg >= PY_W'(1)) && (pos_y_reg <= sy)
                   && (pos_x_reg >= PX_W'(1)) && (pos_x_reg <= sx);
    assign is_last  = (pos_x_reg == sx) && (pos_y_reg == sy) && (pos_z_reg == sz + PZ_W'(1));

    always_comb
    begin
        case (state_reg)
            ST_RD1:  ws_raddr = c_reg - WS_AW'(1);
            ST_RD2:  ws_raddr = c_reg + WS_AW'(1);
            ST_RD3:  ws_raddr = c_reg - WS_AW'(ROW_LEN);
            ST_RD4:  ws_raddr = c_reg + WS_AW'(ROW_LEN);
            default: ws_raddr = cur_addr;
        endcase
    end

    lgm3d_ram #(.WIDTH(WORD_W), .DEPTH(WS_DEPTH), .AW(WS_AW)) u_window (
        .clk   (clk),
        .we    (ws_we),
        .waddr (cur_addr),
        .wdata (sample),
        .raddr (ws_raddr),
        .rdata (ws_rdata)
    );

    lgm3d_ram #(.WIDTH(WORD_W), .DEPTH(MAX_Z), .AW(LV_AW)) u_level (
        .clk   (clk),
        .we    (lv_we),
        .waddr (LV_AW'(level)),
        .wdata (level_inv_spacing),
        .raddr (lv_raddr),
        .rdata (lv_rdata)
    );

    // component operands
    always_comb
    begin
        case (comp_reg)
            2'd0:
            begin
                m_sel = xm_reg; p_sel = xp_reg; inv_sel = cfg.inv_dx;
            end
            2'd1:
            begin
                m_sel = ym_reg; p_sel = yp_reg; inv_sel = cfg.inv_dy;
            end
            default:
            begin
                m_sel = below_reg; p_sel = s_reg; inv_sel = lvl_reg;
            end
        endcase
        diff = {p_sel[31], p_sel} - {m_sel[31], m_sel};
    end

    // shared multiplier
    always_comb
    begin
        case (state_reg)
            ST_HMUL:
            begin
                mul_a = mag_reg[31:0]; mul_b = inv_reg;
            end
            ST_SQ0:
            begin
                mul_a = h_reg[31:0]; mul_b = h_reg[31:0];
            end
            ST_SQ1:
            begin
                mul_a = h_reg[31:0]; mul_b = {15'd0, h_reg[48:32]};
            end
            ST_SQ2:
            begin
                mul_a = {15'd0, h_reg[48:32]}; mul_b = {15'd0, h_reg[48:32]};
            end
            ST_FSQ:
            begin
                mul_a = x_reg; mul_b = x_reg;
            end
            ST_LMUL1:
            begin
                mul_a = {15'd0, lmag_reg[16:0]}; mul_b = LN2_Q30;
            end
            ST_LMUL2:
            begin
                mul_a = {15'd0, lmag_reg[33:17]}; mul_b = LN2_Q30;
            end
            default:
            begin
                mul_a = '0; mul_b = '0;
            end
        endcase
        mul_prod_next = 64'(mul_a) * 64'(mul_b);
    end

    always_comb
    begin
        total    = sat_add(sum_reg, {32'd0, cfg.floor_offset});
        sh       = 7'd32 >> step_reg;
        nv_shift = ((nv_reg >> (7'd64 - sh)) == 64'd0) ? (nv_reg << sh) : nv_reg;
        t        = prod_reg[63:31];
        e_m32    = {1'b0, e_reg} - 7'd32;
        l2       = {e_m32, frac_reg};
        pm       = lneg_reg ? -$signed({1'b0, acc_reg[63:0]}) : $signed({1'b0, acc_reg[63:0]});
        q        = pm + (65'sd1 <<< 33);
        r        = q >>> 34;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            lv_valid_reg  <= '0;
            out_valid_reg <= 1'b0;
            comp_reg      <= '0;
            step_reg      <= '0;
            iter_reg      <= '0;
        end
        else
        begin
            prod_reg <= mul_prod_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (lv_we)
                    begin
                        lv_valid_reg[LV_AW'(level)] <= 1'b1;
                    end
                    if (ws_we)
                    begin
                        s_reg      <= sample;
                        c_reg      <= oth_addr;
                        lv_vld_reg <= lv_valid_reg[lv_raddr];
                        xi_reg     <= IDX_W'(pos_x_reg - PX_W'(1));
                        yi_reg     <= IDX_W'(pos_y_reg - PY_W'(1));
                        zi_reg     <= IDX_W'(pos_z_reg - PZ_W'(2));
                        last_reg   <= is_last;
                        if (interior)
                        begin
                            state_reg <= ST_RD1;
                        end
                        if (pos_x_reg >= sx + PX_W'(1))
                        begin
                            pos_x_reg <= '0;
                            if (pos_y_reg >= sy + PY_W'(1))
                            begin
                                pos_y_reg <= '0;
                                pos_z_reg <= (pos_z_reg >= sz + PZ_W'(1)) ? '0
                                             : pos_z_reg + PZ_W'(1);
                            end
                            else
                            begin
                                pos_y_reg <= pos_y_reg + PY_W'(1);
                            end
                        end
                        else
                        begin
                            pos_x_reg <= pos_x_reg + PX_W'(1);
                        end
                    end
                end
                ST_RD1:
                begin
                    below_reg <= ws_rdata;
                    lvl_reg   <= lv_vld_reg ? lv_rdata : ONE_Q16;
                    state_reg <= ST_RD2;
                end
                ST_RD2:
                begin
                    xm_reg    <= ws_rdata;
                    state_reg <= ST_RD3;
                end
                ST_RD3:
                begin
                    xp_reg    <= ws_rdata;
                    state_reg <= ST_RD4;
                end
                ST_RD4:
                begin
                    ym_reg    <= ws_rdata;
                    state_reg <= ST_RD5;
                end
                ST_RD5:
                begin
                    yp_reg    <= ws_rdata;
                    comp_reg  <= '0;
                    sum_reg   <= '0;
                    state_reg <= ST_MAG;
                end
                ST_MAG:
                begin
                    mag_reg   <= diff[32] ? 33'(-diff) : 33'(diff);
                    inv_reg   <= inv_sel;
                    state_reg <= ST_HMUL;
                end
                ST_HMUL:
                begin
                    state_reg <= ST_HADD;
                end
                ST_HADD:
                begin
                    h_reg     <= prod_reg + (mag_reg[32] ? {inv_reg, 32'd0} : 64'd0);
                    state_reg <= ST_SQ0;
                end
                ST_SQ0:
                begin
                    sat_reg   <= |h_reg[63:49];
                    state_reg <= ST_SQ1;
                end
                ST_SQ1:
                begin
                    acc_reg   <= {34'd0, prod_reg};
                    state_reg <= ST_SQ2;
                end
                ST_SQ2:
                begin
                    acc_reg   <= acc_reg + {1'b0, prod_reg, 33'd0};
                    state_reg <= ST_SQ3;
                end
                ST_SQ3:
                begin
                    acc_reg   <= acc_reg + {prod_reg[33:0], 64'd0};
                    state_reg <= ST_SQACC;
                end
                ST_SQACC:
                begin
                    sum_reg <= sat_add(sum_reg, sat_reg ? {64{1'b1}} : acc_reg[97:34]);
                    if (comp_reg == 2'd2)
                    begin
                        state_reg <= ST_OFF;
                    end
                    else
                    begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= ST_MAG;
                    end
                end
                ST_OFF:
                begin
                    nv_reg   <= total;
                    e_reg    <= 6'd63;
                    step_reg <= '0;
                    if (total == 64'd0)
                    begin
                        res_reg   <= LOG_ZERO;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        state_reg <= ST_NORM;
                    end
                end
                ST_NORM:
                begin
                    nv_reg <= nv_shift;
                    x_reg  <= nv_shift[63:32];
                    if (nv_shift != nv_reg)
                    begin
                        e_reg <= e_reg - 6'(sh);
                    end
                    step_reg <= step_reg + 3'd1;
                    if (step_reg == 3'd5)
                    begin
                        frac_reg  <= '0;
                        iter_reg  <= '0;
                        state_reg <= ST_FSQ;
                    end
                end
                ST_FSQ:
                begin
                    state_reg <= ST_FUPD;
                end
                ST_FUPD:
                begin
                    frac_reg <= {frac_reg[26:0], t[32]};
                    x_reg    <= t[32] ? t[32:1] : t[31:0];
                    iter_reg <= iter_reg + 5'd1;
                    state_reg <= (iter_reg == 5'd27) ? ST_LMUL0 : ST_FSQ;
                end
                ST_LMUL0:
                begin
                    lneg_reg  <= l2[34];
                    lmag_reg  <= l2[34] ? 34'(~l2 + 35'd1) : l2[33:0];
                    state_reg <= ST_LMUL1;
                end
                ST_LMUL1:
                begin
                    state_reg <= ST_LMUL2;
                end
                ST_LMUL2:
                begin
                    acc_reg   <= {34'd0, prod_reg};
                    state_reg <= ST_LMUL3;
                end
                ST_LMUL3:
                begin
                    acc_reg   <= acc_reg + {17'd0, prod_reg, 17'd0};
                    state_reg <= ST_LRND;
                end
                ST_LRND:
                begin
                    res_reg   <= r[31:0];
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        log_grad_reg  <= res_reg;
                        x_index_reg   <= xi_reg;
                        y_index_reg   <= yi_reg;
                        z_index_reg   <= zi_reg;
                        last_out_reg  <= last_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign log_grad  = log_grad_reg;
    assign x_index   = x_index_reg;
    assign y_index   = y_index_reg;
    assign z_index   = z_index_reg;
    assign last      = last_out_reg;

endmodule

@@ hdl/log_gradient_magnitude_3d_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// log_gradient_magnitude_3d_unit
// log of squared central difference gradient magnitude over a padded volume
// ---------------------------------------------------------------------------
// ghost and table beats give no result; each interior voxel gives one, skipping the log on a zero sum
// one beat at a time, set by the shared 32x32 multiplier and 28-step log loop
// reset: stream position zero, level table reads 1.0, window store undefined
// result register holds one finished beat while the next input is taken
module log_gradient_magnitude_3d_unit
    import lgm3d_pkg::*;
#(
    parameter int MAX_X = DEF_MAX_X,
    parameter int MAX_Y = DEF_MAX_Y,
    parameter int MAX_Z = DEF_MAX_Z
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [REG_W-1:0]         cfg_index,
    input  logic [WORD_W-1:0]        cfg_data,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     operation,
    input  logic signed [WORD_W-1:0] sample,
    input  logic [IDX_W-1:0]         level,
    input  logic [WORD_W-1:0]        level_inv_spacing,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [WORD_W-1:0] log_grad,
    output logic [IDX_W-1:0]         x_index,
    output logic [IDX_W-1:0]         y_index,
    output logic [IDX_W-1:0]         z_index,
    output logic                     last
);

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.size_x       <= SIZE_RESET;
            cfg_reg.size_y       <= SIZE_RESET;
            cfg_reg.size_z       <= SIZE_RESET;
            cfg_reg.inv_dx       <= ONE_Q16;
            cfg_reg.inv_dy       <= ONE_Q16;
            cfg_reg.floor_offset <= FLOOR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SIZE_X:       cfg_reg.size_x       <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Y:       cfg_reg.size_y       <= cfg_data[SIZE_W-1:0];
                REG_SIZE_Z:       cfg_reg.size_z       <= cfg_data[SIZE_W-1:0];
                REG_INV_DX:       cfg_reg.inv_dx       <= cfg_data;
                REG_INV_DY:       cfg_reg.inv_dy       <= cfg_data;
                REG_FLOOR_OFFSET: cfg_reg.floor_offset <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    lgm3d_core #(.MAX_X(MAX_X), .MAX_Y(MAX_Y), .MAX_Z(MAX_Z)) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .operation         (operation),
        .sample            (sample),
        .level             (level),
        .level_inv_spacing (level_inv_spacing),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .log_grad          (log_grad),
        .x_index           (x_index),
        .y_index           (y_index),
        .z_index           (z_index),
        .last              (last)
    );

endmodule
